// File: sv/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types, constants and elaboration helpers for the signed integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;

    // bits of magnitude folded into the bcd register per cycle
    localparam int BITS_PER_STEP = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEAD,
        ST_EMIT
    } sitoa_state_t;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } sitoa_qstat_t;

    // number of decimal digits of the largest magnitude, 2^(width-1)
    function automatic int digit_count(input int width);
        longint unsigned v;
        int d;
        v = 64'd1 << (width - 1);
        d = 1;
        for (int i = 0; i < 20; i++) begin
            if (v >= 64'd10) begin
                v = v / 64'd10;
                d = d + 1;
            end
        end
        return d;
    endfunction

endpackage

// File: sv/sitoa_front.sv
// ----------------------------------------------------------------------------
// sitoa_front
// Accepts a transaction, splits the value into sign and unsigned magnitude
// and pushes the pair into the queue.
// ----------------------------------------------------------------------------
module sitoa_front #(
    parameter int VALUE_WIDTH = sitoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                       start,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  sitoa_pkg::sitoa_qstat_t    qstat,
    output logic                       busy,
    output logic                       push,
    output logic [VALUE_WIDTH:0]       push_data
);
    import sitoa_pkg::*;

    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;

    // take a transaction whenever the queue has room
    assign busy = qstat.full;
    assign push = start && !qstat.full;

    // sign and magnitude; the most negative value maps onto itself as unsigned
    assign negative  = value[VALUE_WIDTH-1];
    assign magnitude = negative ? (~value + 1'b1) : value;
    assign push_data = {negative, magnitude};

endmodule

// File: sv/sitoa_queue.sv
// ----------------------------------------------------------------------------
// sitoa_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module sitoa_queue #(
    parameter int DATA_WIDTH = sitoa_pkg::DEFAULT_VALUE_WIDTH + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [DATA_WIDTH-1:0]   push_data,
    input  logic                    pop,
    output logic [DATA_WIDTH-1:0]   pop_data,
    output sitoa_pkg::sitoa_qstat_t qstat
);
    import sitoa_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  do_push;
    logic                  do_pop;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/sitoa_back.sv
// ----------------------------------------------------------------------------
// sitoa_back
// Converts the magnitude to bcd by shift-and-add-3, four bits a cycle, then
// emits the sign and the digits most significant first.
// ----------------------------------------------------------------------------
module sitoa_back #(
    parameter int VALUE_WIDTH = sitoa_pkg::DEFAULT_VALUE_WIDTH,
    parameter int NUM_DIGITS  = sitoa_pkg::digit_count(sitoa_pkg::DEFAULT_VALUE_WIDTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sitoa_pkg::sitoa_qstat_t qstat,
    input  logic [VALUE_WIDTH:0]    pop_data,
    output logic                    pop,
    output logic                    strobe,
    output logic [7:0]              character,
    output logic                    last
);
    import sitoa_pkg::*;

    localparam int STEPS   = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int SH_W    = STEPS * BITS_PER_STEP;
    localparam int BCD_W   = NUM_DIGITS * 4;
    localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int IDX_W   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    sitoa_state_t       state_reg;
    sitoa_state_t       state_next;
    logic [SH_W-1:0]    sh_reg;
    logic [SH_W-1:0]    sh_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic               neg_reg;
    logic               neg_next;
    logic [STEP_CW-1:0] step_reg;
    logic [STEP_CW-1:0] step_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               strobe_reg;
    logic               strobe_next;
    logic [7:0]         character_reg;
    logic [7:0]         character_next;
    logic               last_reg;
    logic               last_next;

    logic [BCD_W-1:0]   conv_bcd;
    logic [SH_W-1:0]    conv_sh;
    logic [IDX_W-1:0]   lead_idx;
    logic [3:0]         cur_digit;

    // four shift-and-add-3 steps per cycle
    always_comb
    begin
        conv_bcd = bcd_reg;
        conv_sh  = sh_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (conv_bcd[d*4 +: 4] >= 4'd5)
                begin
                    conv_bcd[d*4 +: 4] = conv_bcd[d*4 +: 4] + 4'd3;
                end
            end
            conv_bcd = {conv_bcd[BCD_W-2:0], conv_sh[SH_W-1]};
            conv_sh  = {conv_sh[SH_W-2:0], 1'b0};
        end
    end

    // highest non-zero digit, zero when all digits are zero
    always_comb
    begin
        lead_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                lead_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        strobe_next    = 1'b0;
        character_next = character_reg;
        last_next      = 1'b0;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    neg_next   = pop_data[VALUE_WIDTH];
                    sh_next    = SH_W'(pop_data[VALUE_WIDTH-1:0]);
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                sh_next   = conv_sh;
                bcd_next  = conv_bcd;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_CW'(STEPS - 1))
                begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD:
            begin
                idx_next = lead_idx;
                if (neg_reg)
                begin
                    strobe_next    = 1'b1;
                    character_next = CHAR_MINUS;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next    = 1'b1;
                character_next = CHAR_ZERO + {4'd0, cur_digit};
                last_next      = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        sh_reg        <= sh_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        step_reg      <= step_next;
        idx_reg       <= idx_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg;

endmodule

// File: sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ascii text, one character per result, sign first.
//
//   channel  ports                        handshake
//   -------  ---------------------------  ------------------------------
//   input    value                        start high while busy low
//   result   character, last              strobe high for one cycle
//
// A value is held in a two-entry queue until the converter takes it. The
// converter loads it, runs shift-and-add-3 four bits at a time, finds the
// leading digit (and shows the minus sign), then emits one digit per cycle;
// it takes the next value from the queue only once the last digit is out.
// Reset clears the queue and the sequencer; no clearing pass is needed.
// The result side has no back-pressure; busy rises only when the queue is full.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sitoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          strobe,
    output logic [7:0]                    character,
    output logic                          last
);
    import sitoa_pkg::*;

    localparam int NUM_DIGITS = digit_count(VALUE_WIDTH);

    sitoa_qstat_t         qstat;
    logic                 push;
    logic [VALUE_WIDTH:0] push_data;
    logic                 pop;
    logic [VALUE_WIDTH:0] pop_data;

    sitoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .start     (start),
        .value     (value),
        .qstat     (qstat),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    sitoa_queue #(
        .DATA_WIDTH (VALUE_WIDTH + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    sitoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop_data  (pop_data),
        .pop       (pop),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule

// File: sv/sitoa_checker.sv
// ----------------------------------------------------------------------------
// sitoa_checker
// Port-level checks on the character stream of the converter.
// ----------------------------------------------------------------------------
module sitoa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] character,
    input logic       last
);
    import sitoa_pkg::*;

    // only a minus sign or a decimal digit is ever emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (character == CHAR_MINUS) ||
                   ((character >= CHAR_ZERO) && (character <= CHAR_ZERO + 8'd9)))
        else $error("sitoa: character outside sign and digits");

    // a minus sign never closes a number
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && character == CHAR_MINUS) |-> !last)
        else $error("sitoa: minus sign flagged last");

    // a digit follows the minus sign in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && character == CHAR_MINUS) |=> (strobe && character != CHAR_MINUS))
        else $error("sitoa: no digit after minus sign");

    // a zero that is not the final character is never a leading zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last && character == CHAR_ZERO) |->
            ($past(strobe) && !$past(last) && $past(character) != CHAR_MINUS))
        else $error("sitoa: leading zero emitted");

    // the queue only fills on a taken transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("sitoa: busy rose without a transaction");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_checker (.*);

// File: tb/signed_int_to_decimal_ascii_checker.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_checker
// Watches the command and result channels of the signed integer to decimal
// text converter. Every accepted value is rendered into its expected text,
// one character per entry, and every strobed character is compared with the
// oldest entry still waiting.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_checker #(
    parameter int VALUE_WIDTH = sitoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   strobe,
    input  logic [7:0]             character,
    input  logic                   last,
    output int                     error_count,
    output int                     pending,
    output int                     accepted,
    output int                     received
);

    // one expected character of the decimal text
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_char_t;

    text_char_t text_q[$];

    int errs_r     = 0;
    int accepted_r = 0;
    int received_r = 0;

    // print one line and count it
    task automatic flag_mismatch(input string msg);
        $display("%0t checker: %s", $time, msg);
        errs_r++;
    endtask

    // append the decimal text of one value, sign first, to the expected text
    function automatic void render_decimal(input logic [VALUE_WIDTH-1:0] v);
        logic                   negative;
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] digit;
        logic [7:0]             digits [24];
        int                     nd;
        text_char_t             c;
        negative = v[VALUE_WIDTH-1];
        // unsigned magnitude, so the most negative value does not overflow
        mag = negative ? (~v + 1'b1) : v;
        nd = 0;
        do
        begin
            digit = mag % 10;
            digits[nd] = sitoa_pkg::CHAR_ZERO + digit[7:0];
            nd++;
            mag = mag / 10;
        end
        while (mag != 0 && nd < 24);
        if (negative)
        begin
            c.ch  = sitoa_pkg::CHAR_MINUS;
            c.fin = 1'b0;
            text_q.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.ch  = digits[k];
            c.fin = (k == 0);
            text_q.push_back(c);
        end
    endfunction

    // compare results first, then queue the text of a newly accepted value
    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (rst_n)
        begin
            if (strobe === 1'b1)
            begin
                received_r++;
                if (text_q.size() == 0)
                    flag_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                            character, last));
                else
                begin
                    exp_c = text_q.pop_front();
                    if (character !== exp_c.ch)
                        flag_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                                character, exp_c.ch));
                    if (last !== exp_c.fin)
                        flag_mismatch($sformatf("last %0b on 0x%02h, expected %0b",
                                                last, exp_c.ch, exp_c.fin));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                accepted_r++;
                render_decimal(value);
            end
        end
        error_count <= errs_r;
        pending     <= text_q.size();
        accepted    <= accepted_r;
        received    <= received_r;
    end

endmodule

// File: tb/signed_int_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed values into the decimal text converter: edge values first,
// then random values spread over every digit count, with random input gaps,
// a full drain half way through and a gap-free tail. Checking is done by the
// checker instance beside the block.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

    localparam int VALUE_WIDTH  = sitoa_pkg::DEFAULT_VALUE_WIDTH;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_TAIL    = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          busy;
    logic                          strobe;
    logic [7:0]                    character;
    logic                          last;

    int error_count;
    int pending;
    int accepted;
    int received;
    int cycles = 0;

    int edge_values [] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                           32'h7fffffff, 32'h80000000, 32'h80000001,
                           999999999, -999999999, 1000000000, -1000000000,
                           123456789, -123456789, 2000000000,
                           32'h55555555, 32'haaaaaaaa};

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    signed_int_to_decimal_ascii_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .strobe      (strobe),
        .character   (character),
        .last        (last),
        .error_count (error_count),
        .pending     (pending),
        .accepted    (accepted),
        .received    (received)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("signed_int_to_decimal_ascii_tb: done, errors");
        $finish;
    end

    // offer one value and hold it until the transaction is taken
    task automatic push_value(input logic [VALUE_WIDTH-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // sender gap with noise on the value port
    task automatic hold_off(input int n);
        start <= 1'b0;
        value <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // stop sending until every expected character has come out
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned pow10(input int k);
        int unsigned p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    // random value weighted over digit counts, powers of ten and extremes
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        int                     k;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1:
            begin
                k = $urandom_range(1, 9);
                v = $urandom_range(0, pow10(k));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            2:
            begin
                k = $urandom_range(0, 9);
                v = pow10(k) + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}} - $urandom_range(0, 20);
                    1: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(0, 20);
                    default: v = $urandom_range(0, 40) - 20;
                endcase
            end
        endcase
        return v;
    endfunction

    // stimulus and verdict
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge values back to back, so the input queue fills
        foreach (edge_values[i])
            push_value(edge_values[i]);
        wait_drained();

        // random values with gaps, a drain half way and a calm tail
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 15));
            push_value(pick_value());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d values (edge values, every digit count, both signs)",
                 accepted);
        $display("and %0d characters, with sender gaps and a mid-run drain", received);
        if (error_count == 0)
            $display("signed_int_to_decimal_ascii_tb: done, clean");
        else
            $display("signed_int_to_decimal_ascii_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
sv/sitoa_pkg.sv
sv/sitoa_front.sv
sv/sitoa_queue.sv
sv/sitoa_back.sv
sv/signed_int_to_decimal_ascii.sv
sv/sitoa_checker.sv
tb/signed_int_to_decimal_ascii_checker.sv
tb/signed_int_to_decimal_ascii_tb.sv
